// ===== rtl/core/i2css_pkg.sv =====
`timescale 1ns / 1ps

package i2css_pkg;

   localparam int DEF_SCHEDULE_DEPTH = 16;
   localparam int DEF_BUFFER_DEPTH   = 16;

   localparam int OP_W     = 2;
   localparam int CMD_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int IDX_W    = 4;
   localparam int ACTIVE_W = 5;
   localparam int KIND_W   = 2;
   localparam int ACTION_W = 3;
   localparam int COUNT_W  = 5;
   localparam int ENTRY_W  = CMD_W + BYTE_W;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
   localparam logic [OP_W-1:0] OP_EVENT   = 2'd2;

   localparam logic [CMD_W-1:0] CMD_HALT        = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START       = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE       = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ_FIRST  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ_MIDDLE = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ_LAST   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_READ_SINGLE = 3'd6;

   localparam logic [ACTION_W-1:0] ACT_NONE    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_START   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_SEND    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RX_ACK  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_RX_NACK = 3'd4;

   localparam logic [KIND_W-1:0] KIND_ACTION = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NOACT  = 2'd2;

   typedef struct packed {
      logic capture;
      logic exec_load;
      logic exec_restart;
      logic exec_event;
      logic noact_emit;
      logic pub_emit;
      logic cmd_emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            halted;
      logic            pub_needed;
      logic            pub_last;
      logic            out_free;
   } ctrl_sts_type;

endpackage

// ===== rtl/core/i2c_schedule_sequencer.sv =====
`timescale 1ns / 1ps

// Interrupt-style I2C master sequencer: walks a stored command schedule, one step per
// bus completion item, gathering read bytes and publishing them as a run of data items
// ahead of the next bus action. Every input item yields exactly one item with tlast set.
// Load, restart and ignored events emit that item from the execute step; a bus event from
// the command step, after a prefetch and one data item per buffered byte on a read-last
// step, one per cycle from the gather buffer's registered read port while rsp_tready is
// high. Configuration must be written only while the block is idle; it is not enforced.
module i2c_schedule_sequencer #(
   parameter int SCHEDULE_DEPTH = i2css_pkg::DEF_SCHEDULE_DEPTH,
   parameter int BUFFER_DEPTH   = i2css_pkg::DEF_BUFFER_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // entry_index, entry_command, entry_param, received_byte, zero pad
   input  logic [i2css_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation
   input  logic [i2css_pkg::OP_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // bus_action, bus_byte, data_byte, data_count, overflow, zero pad
   output logic [i2css_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // kind
   output logic [i2css_pkg::KIND_W-1:0]       rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_wr_en,
   input  logic [i2css_pkg::ACTIVE_W-1:0]     csr_wr_data
);

   import i2css_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   i2css_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   i2css_dp #(
      .SCHEDULE_DEPTH (SCHEDULE_DEPTH),
      .BUFFER_DEPTH   (BUFFER_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// ===== rtl/core/i2css_ram.sv =====
`timescale 1ns / 1ps

module i2css_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/i2css_ctrl.sv =====
`timescale 1ns / 1ps

module i2css_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  i2css_pkg::ctrl_sts_type sts,
   output i2css_pkg::ctrl_cmd_type cmd
);

   import i2css_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_PFETCH = 3'd2;
   localparam logic [2:0] ST_PUB    = 3'd3;
   localparam logic [2:0] ST_CMD    = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.op == OP_EVENT && !sts.halted) begin
               cmd.exec_event = 1'b1;
               state_in       = sts.pub_needed ? ST_PFETCH : ST_CMD;
            end else if (sts.out_free) begin
               cmd.exec_load    = (sts.op == OP_LOAD);
               cmd.exec_restart = (sts.op == OP_RESTART);
               cmd.noact_emit   = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_PFETCH: begin
            state_in = ST_PUB;
         end
         ST_PUB: begin
            if (sts.out_free) begin
               cmd.pub_emit = 1'b1;
               if (sts.pub_last) begin
                  state_in = ST_CMD;
               end
            end
         end
         ST_CMD: begin
            if (sts.out_free) begin
               cmd.cmd_emit = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   a_pub_needs_pfetch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUB) |-> ($past(state_ff) == ST_PFETCH || $past(state_ff) == ST_PUB))
      else $error("publish entered without prefetch");

   a_event_leads_on: assert property (@(posedge clock) disable iff (reset)
      cmd.exec_event |=> (state_ff == ST_PFETCH || state_ff == ST_CMD))
      else $error("bus event did not proceed to publish or command step");

   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.noact_emit, cmd.pub_emit, cmd.cmd_emit}))
      else $error("more than one result loaded at once");

endmodule

// ===== rtl/core/i2css_dp.sv =====
`timescale 1ns / 1ps

module i2css_dp #(
   parameter int SCHEDULE_DEPTH = i2css_pkg::DEF_SCHEDULE_DEPTH,
   parameter int BUFFER_DEPTH   = i2css_pkg::DEF_BUFFER_DEPTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [i2css_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  logic [i2css_pkg::OP_W-1:0]              req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [i2css_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [i2css_pkg::KIND_W-1:0]            rsp_tuser,
   output logic                                    rsp_tlast,
   input  logic                                    csr_wr_en,
   input  logic [i2css_pkg::ACTIVE_W-1:0]          csr_wr_data,
   input  i2css_pkg::ctrl_cmd_type                 cmd,
   output i2css_pkg::ctrl_sts_type                 sts
);

   import i2css_pkg::*;

   localparam int PW    = (SCHEDULE_DEPTH > 1) ? $clog2(SCHEDULE_DEPTH) : 1;
   localparam int CNT_W = $clog2(SCHEDULE_DEPTH + 1);
   localparam int BW    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int FW    = $clog2(BUFFER_DEPTH + 1);

   logic [ACTIVE_W-1:0] csr_ff;
   logic [OP_W-1:0]     op_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [CMD_W-1:0]    ecmd_ff;
   logic [BYTE_W-1:0]   par_ff;
   logic [BYTE_W-1:0]   rx_ff;

   logic [PW-1:0] pos_ff;
   logic          started_ff;
   logic          rp_ff;
   logic          rfp_ff;
   logic          rlp_ff;
   logic [FW-1:0] fill_ff;
   logic          dropped_ff;
   logic          halted_ff;
   logic [FW-1:0] pub_ff;

   logic                rsp_valid_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [ACTION_W-1:0] action_ff;
   logic [BYTE_W-1:0]   bus_byte_ff;
   logic [BYTE_W-1:0]   data_byte_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic                ovf_ff;
   logic                last_ff;

   logic [CNT_W-1:0]   eff;
   logic [CNT_W-1:0]   pos_inc;
   logic [PW-1:0]      pos_in;
   logic [FW-1:0]      fill_base;
   logic               buf_wr;
   logic [FW-1:0]      fill_in;
   logic [FW-1:0]      pub_inc;
   logic               sched_wr;
   logic [ENTRY_W-1:0] sched_rdata;
   logic [BYTE_W-1:0]  buf_rdata;
   logic [BW-1:0]      buf_raddr;
   logic [CMD_W-1:0]   code;
   logic [ACTION_W-1:0] act;

   always_comb begin
      if (csr_ff == '0 || 32'(csr_ff) > SCHEDULE_DEPTH) begin
         eff = CNT_W'(SCHEDULE_DEPTH);
      end else begin
         eff = CNT_W'(csr_ff);
      end
      pos_inc = CNT_W'(pos_ff) + CNT_W'(1);
      if (!started_ff || pos_inc >= eff) begin
         pos_in = '0;
      end else begin
         pos_in = PW'(pos_inc);
      end
      fill_base = rfp_ff ? '0 : fill_ff;
      buf_wr    = cmd.exec_event && rp_ff && (32'(fill_base) < BUFFER_DEPTH);
      fill_in   = buf_wr ? fill_base + FW'(1) : fill_base;
      pub_inc   = pub_ff + FW'(1);
      buf_raddr = cmd.pub_emit ? BW'(pub_inc) : BW'(pub_ff);
      sched_wr  = cmd.exec_load && (32'(idx_ff) < SCHEDULE_DEPTH);
   end

   i2css_ram #(.WIDTH(ENTRY_W), .DEPTH(SCHEDULE_DEPTH)) u_sched (
      .clock   (clock),
      .wr_en   (sched_wr),
      .wr_addr (PW'(idx_ff)),
      .wr_data ({par_ff, ecmd_ff}),
      .rd_en   (cmd.exec_event),
      .rd_addr (pos_in),
      .rd_data (sched_rdata)
   );

   i2css_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_DEPTH)) u_buf (
      .clock   (clock),
      .wr_en   (buf_wr),
      .wr_addr (BW'(fill_base)),
      .wr_data (rx_ff),
      .rd_en   (1'b1),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   always_comb begin
      code = sched_rdata[CMD_W-1:0];
      case (code)
         CMD_START:       act = ACT_START;
         CMD_WRITE:       act = ACT_SEND;
         CMD_READ_FIRST:  act = ACT_RX_ACK;
         CMD_READ_MIDDLE: act = ACT_RX_ACK;
         CMD_READ_LAST:   act = ACT_RX_NACK;
         CMD_READ_SINGLE: act = ACT_RX_NACK;
         default:         act = ACT_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_tuser;
         idx_ff  <= req_tdata[3:0];
         ecmd_ff <= req_tdata[6:4];
         par_ff  <= req_tdata[14:7];
         rx_ff   <= req_tdata[22:15];
      end
      if (cmd.noact_emit) begin
         kind_ff      <= KIND_NOACT;
         action_ff    <= ACT_NONE;
         bus_byte_ff  <= '0;
         data_byte_ff <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b1;
      end else if (cmd.pub_emit) begin
         kind_ff      <= KIND_DATA;
         action_ff    <= ACT_NONE;
         bus_byte_ff  <= '0;
         data_byte_ff <= buf_rdata;
         count_ff     <= COUNT_W'(fill_ff);
         ovf_ff       <= dropped_ff;
         last_ff      <= 1'b0;
      end else if (cmd.cmd_emit) begin
         kind_ff      <= (act == ACT_NONE) ? KIND_NOACT : KIND_ACTION;
         action_ff    <= act;
         bus_byte_ff  <= (act == ACT_SEND) ? sched_rdata[ENTRY_W-1:CMD_W] : '0;
         data_byte_ff <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= ACTIVE_RESET;
         pos_ff       <= '0;
         started_ff   <= 1'b0;
         rp_ff        <= 1'b0;
         rfp_ff       <= 1'b0;
         rlp_ff       <= 1'b0;
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         halted_ff    <= 1'b1;
         pub_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         if (cmd.exec_restart) begin
            pos_ff     <= '0;
            started_ff <= 1'b0;
            rp_ff      <= 1'b0;
            rfp_ff     <= 1'b0;
            rlp_ff     <= 1'b0;
            halted_ff  <= 1'b0;
         end
         if (cmd.exec_event) begin
            fill_ff    <= fill_in;
            dropped_ff <= (rfp_ff ? 1'b0 : dropped_ff) | (rp_ff && !buf_wr);
            rp_ff      <= 1'b0;
            rfp_ff     <= 1'b0;
            rlp_ff     <= 1'b0;
            pos_ff     <= pos_in;
            started_ff <= 1'b1;
            pub_ff     <= '0;
         end
         if (cmd.pub_emit) begin
            pub_ff <= pub_inc;
         end
         if (cmd.cmd_emit) begin
            case (code)
               CMD_START, CMD_WRITE: begin
               end
               CMD_READ_FIRST: begin
                  rp_ff  <= 1'b1;
                  rfp_ff <= 1'b1;
               end
               CMD_READ_MIDDLE: begin
                  rp_ff <= 1'b1;
               end
               CMD_READ_LAST: begin
                  rp_ff  <= 1'b1;
                  rlp_ff <= 1'b1;
               end
               CMD_READ_SINGLE: begin
                  rp_ff  <= 1'b1;
                  rfp_ff <= 1'b1;
                  rlp_ff <= 1'b1;
               end
               default: begin
                  halted_ff <= 1'b1;
               end
            endcase
         end
         if (cmd.noact_emit || cmd.pub_emit || cmd.cmd_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // buffer is non-empty after the event when a byte lands or one was already held
   assign sts.op         = op_ff;
   assign sts.halted     = halted_ff;
   assign sts.pub_needed = rlp_ff && (rp_ff || fill_base != '0);
   assign sts.pub_last   = (pub_inc == fill_ff);
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {7'd0, ovf_ff, count_ff, data_byte_ff, bus_byte_ff, action_ff};

   a_pub_has_data: assert property (@(posedge clock) disable iff (reset)
      cmd.pub_emit |-> (fill_ff != '0 && pub_ff < fill_ff))
      else $error("publish beyond buffer fill");

   a_pub_not_last: assert property (@(posedge clock) disable iff (reset)
      cmd.pub_emit |=> (rsp_valid_ff && !last_ff && kind_ff == KIND_DATA))
      else $error("published byte not presented as data item");

   a_cmd_last: assert property (@(posedge clock) disable iff (reset)
      cmd.cmd_emit |=> (rsp_valid_ff && last_ff))
      else $error("command step result not marked last");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> (32'(pos_ff) < SCHEDULE_DEPTH))
      else $error("schedule position out of range");

endmodule
